>>> rtl/core/lcsrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsrr_pkg
// Shared constants and types for the rolling-row LCS length block.
// ----------------------------------------------------------------------------
package lcsrr_pkg;

  localparam int MAX_LEN     = 64;
  localparam int SYMBOL_BITS = 8;

  localparam int SYM_IN_W = 8;
  localparam int LEN_W    = 7;
  localparam int SYM_W    = (SYMBOL_BITS < SYM_IN_W) ? SYMBOL_BITS : SYM_IN_W;
  localparam int SCORE_W  = $clog2(MAX_LEN + 1);
  localparam int CNT_W    = $clog2(MAX_LEN + 1);

  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // Data handed from one cell to the next each cycle.
  typedef struct packed {
    logic   valid;
    logic   last;
    sym_t   sym;
    score_t left;
    score_t diag;
  } wave_t;

  // Per-cell load/clear control.
  typedef struct packed {
    logic clr;
    logic load;
    sym_t sym;
  } cell_ctl_t;

endpackage

>>> rtl/core/lcsrr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsrr_in_if
// Input channel: one reference or query symbol per word.
// ----------------------------------------------------------------------------
interface lcsrr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] symbol;
  logic       is_last;

  modport source (output valid, output mode, output symbol, output is_last, input ready);
  modport sink   (input valid, input mode, input symbol, input is_last, output ready);
endinterface

>>> rtl/core/lcsrr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsrr_out_if
// Result channel: LCS length and truncation flag, one word per query.
// ----------------------------------------------------------------------------
interface lcsrr_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] lcs_length;
  logic       ref_truncated;

  modport source (output valid, output lcs_length, output ref_truncated, input ready);
  modport sink   (input valid, input lcs_length, input ref_truncated, output ready);
endinterface

>>> rtl/core/lcsrr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsrr_cell
// One column of the score row: holds a reference symbol and its score,
// updates it as a query symbol passes and forwards the wave to the next cell.
// ----------------------------------------------------------------------------
module lcsrr_cell
  import lcsrr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  wave_t     wave_in,
  output wave_t     wave_out
);

  logic   active_r, active_nxt;
  sym_t   ref_sym_r;
  score_t score_r, score_nxt;
  score_t new_score;
  wave_t  wave_r, wave_nxt;

  always_comb begin
    if (ref_sym_r == wave_in.sym) begin
      new_score = wave_in.diag + score_t'(1);
    end else if (score_r > wave_in.left) begin
      new_score = score_r;
    end else begin
      new_score = wave_in.left;
    end
  end

  always_comb begin
    active_nxt = active_r;
    score_nxt  = score_r;
    wave_nxt   = wave_in;
    if (ctl.clr) begin
      active_nxt = 1'b0;
      score_nxt  = '0;
    end
    if (ctl.load) begin
      active_nxt = 1'b1;
    end
    if (active_r && wave_in.valid) begin
      score_nxt     = wave_in.last ? score_t'(0) : new_score;
      wave_nxt.left = new_score;
      wave_nxt.diag = score_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      score_r  <= '0;
      wave_r   <= '0;
    end else begin
      active_r <= active_nxt;
      score_r  <= score_nxt;
      wave_r   <= wave_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ref_sym_r <= ctl.sym;
    end
  end

  assign wave_out = wave_r;

endmodule

>>> rtl/core/lcs_length_rolling_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_length_rolling_row
// LCS length of a stored reference string against streamed query strings.
//
// in_ch carries words {mode, symbol, is_last}. Mode 0 words load reference
// symbols into a row of MAX_LEN cells; is_last ends the reference, and a
// mode 0 word after a finished reference starts a new one. Symbols past
// MAX_LEN are dropped and flagged. Mode 1 words are query symbols: each
// travels down the cell row one cell per cycle, so non-final query words
// are taken every cycle. The query word with is_last produces one word on
// out_ch {lcs_length, ref_truncated} once it has left the last cell, and
// leaves the row cleared for the next query.
// A final query word is held off while a result is pending or out_ch holds
// an untaken word; a reference word is held off until all query words have
// left the cell row. The row depth MAX_LEN sets the result latency.
// out_ch holds its word until taken; stalling it only blocks the next final
// query word. Reset (synchronous, rst_n low) empties the row, clears all
// scores and the reference length, and drops any pending result.
// ----------------------------------------------------------------------------
module lcs_length_rolling_row
  import lcsrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lcsrr_in_if.sink    in_ch,
  lcsrr_out_if.source out_ch
);

  localparam int FLT_W = $clog2(MAX_LEN + 1);

  logic             done_r, done_nxt;
  logic             trunc_r, trunc_nxt;
  cnt_t             count_r, count_nxt;
  cnt_t             count_eff;
  logic [FLT_W-1:0] inflight_r, inflight_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0] out_len_r;
  logic             out_trunc_r;

  logic  acc, acc_ref, acc_qry, ld, tail_done;
  wave_t wave [MAX_LEN+1];

  always_comb begin
    if (!in_ch.mode) begin
      in_ch.ready = (inflight_r == '0);
    end else if (in_ch.is_last) begin
      in_ch.ready = !pend_r && !out_valid_r;
    end else begin
      in_ch.ready = 1'b1;
    end
  end

  assign acc       = in_ch.valid && in_ch.ready;
  assign acc_ref   = acc && !in_ch.mode;
  assign acc_qry   = acc && in_ch.mode;
  assign count_eff = done_r ? cnt_t'(0) : count_r;
  assign ld        = acc_ref && (count_eff < cnt_t'(MAX_LEN));
  assign tail_done = wave[MAX_LEN].valid && wave[MAX_LEN].last;

  assign wave[0].valid = acc_qry;
  assign wave[0].last  = in_ch.is_last;
  assign wave[0].sym   = in_ch.symbol[SYM_W-1:0];
  assign wave[0].left  = '0;
  assign wave[0].diag  = '0;

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.clr  = acc_ref && done_r;
    assign ctl.load = ld && (count_eff == cnt_t'(j));
    assign ctl.sym  = in_ch.symbol[SYM_W-1:0];

    lcsrr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wave_in  (wave[j]),
      .wave_out (wave[j+1])
    );
  end

  always_comb begin
    done_nxt  = done_r;
    trunc_nxt = trunc_r;
    count_nxt = count_r;
    if (acc_ref) begin
      count_nxt = count_eff;
      if (done_r) begin
        trunc_nxt = 1'b0;
      end
      if (ld) begin
        count_nxt = count_eff + cnt_t'(1);
      end else begin
        trunc_nxt = 1'b1;
      end
      done_nxt = in_ch.is_last;
    end else if (acc_qry) begin
      done_nxt = 1'b1;
    end
  end

  always_comb begin
    inflight_nxt = inflight_r;
    if (acc_qry && !wave[MAX_LEN].valid) begin
      inflight_nxt = inflight_r + FLT_W'(1);
    end else if (!acc_qry && wave[MAX_LEN].valid) begin
      inflight_nxt = inflight_r - FLT_W'(1);
    end
  end

  always_comb begin
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (tail_done) begin
      pend_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end
    if (acc_qry && in_ch.is_last) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= 1'b0;
      trunc_r     <= 1'b0;
      count_r     <= '0;
      inflight_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      trunc_r     <= trunc_nxt;
      count_r     <= count_nxt;
      inflight_r  <= inflight_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tail_done) begin
      out_len_r   <= LEN_W'(wave[MAX_LEN].left);
      out_trunc_r <= trunc_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.lcs_length    = out_len_r;
  assign out_ch.ref_truncated = out_trunc_r;

  a_tail_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
    tail_done |-> pend_r)
    else $error("result left the row with no final query pending");

  a_tail_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    tail_done |-> !out_valid_r)
    else $error("result arrived while output word still held");

  a_ref_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
    acc_ref |-> (inflight_r == '0) && !wave[MAX_LEN].valid)
    else $error("reference word taken while queries in flight");

  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= FLT_W'(MAX_LEN))
    else $error("in-flight count exceeds row depth");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(MAX_LEN))
    else $error("reference count exceeds capacity");

endmodule

>>> test/lcsrr_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsrr_tb_pkg
// Word mode codes shared by the LCS length testbench and its checker.
// ----------------------------------------------------------------------------
package lcsrr_tb_pkg;

  typedef enum logic {
    MODE_REF   = 1'b0,
    MODE_QUERY = 1'b1
  } word_mode_e;

endpackage

>>> test/lcsrr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsrr_checker
// Watches both channels of the rolling-row LCS block, keeps its own copy of
// the reference store and score row, and checks every result word in order.
// ----------------------------------------------------------------------------
module lcsrr_checker
  import lcsrr_pkg::*;
  import lcsrr_tb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lcsrr_in_if  in_mon,
  lcsrr_out_if out_mon,
  output int   fail_count,
  output int   pending,
  output int   results_checked,
  output int   longest_seen,
  output int   truncated_seen
);

  typedef struct packed {
    logic [LEN_W-1:0] lcs_length;
    logic             ref_truncated;
  } lcs_word_t;

  sym_t      ref_sym [MAX_LEN];
  int        ref_len;
  logic      ref_closed;
  logic      ref_trunc;
  score_t    row_score [MAX_LEN];
  lcs_word_t lcs_due [$];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic score_word(input word_mode_e m, input sym_t s, input logic l);
    score_t    diag_s;
    score_t    left_s;
    score_t    above_s;
    lcs_word_t w;
    if (m == MODE_REF) begin
      if (ref_closed) begin
        ref_len    = 0;
        ref_trunc  = 1'b0;
        ref_closed = 1'b0;
        row_score  = '{default: '0};
      end
      if (ref_len < MAX_LEN) begin
        ref_sym[ref_len] = s;
        ref_len++;
      end else begin
        ref_trunc = 1'b1;
      end
      if (l) ref_closed = 1'b1;
    end else begin
      ref_closed = 1'b1;
      diag_s     = '0;
      left_s     = '0;
      for (int j = 0; j < ref_len; j++) begin
        above_s = row_score[j];
        if (ref_sym[j] == s) row_score[j] = score_t'(diag_s + 1'b1);
        else row_score[j] = (above_s > left_s) ? above_s : left_s;
        left_s = row_score[j];
        diag_s = above_s;
      end
      if (l) begin
        w.lcs_length    = (ref_len > 0) ? LEN_W'(row_score[ref_len-1]) : '0;
        w.ref_truncated = ref_trunc;
        lcs_due.push_back(w);
        row_score = '{default: '0};
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    lcs_word_t w;
    if (!rst_n) begin
      ref_len         = 0;
      ref_closed      = 1'b0;
      ref_trunc       = 1'b0;
      row_score       = '{default: '0};
      lcs_due.delete();
      fail_count      = 0;
      results_checked = 0;
      longest_seen    = 0;
      truncated_seen  = 0;
    end else begin
      // result side first: a result can never belong to this cycle's input word
      if (out_mon.valid && out_mon.ready) begin
        if (lcs_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result word: lcs_length=%0d ref_truncated=%0b",
                                    out_mon.lcs_length, out_mon.ref_truncated));
        end else begin
          w = lcs_due.pop_front();
          results_checked++;
          if (out_mon.lcs_length !== w.lcs_length)
            report_mismatch($sformatf("result %0d: lcs_length %0d, expected %0d",
                                      results_checked, out_mon.lcs_length, w.lcs_length));
          if (out_mon.ref_truncated !== w.ref_truncated)
            report_mismatch($sformatf("result %0d: ref_truncated %0b, expected %0b",
                                      results_checked, out_mon.ref_truncated,
                                      w.ref_truncated));
          if (int'(w.lcs_length) > longest_seen) longest_seen = w.lcs_length;
          if (w.ref_truncated) truncated_seen++;
        end
      end
      if (in_mon.valid && in_mon.ready)
        score_word(word_mode_e'(in_mon.mode), sym_t'(in_mon.symbol), in_mon.is_last);
    end
    pending = lcs_due.size();
  end

endmodule

>>> test/lcs_length_rolling_row_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_length_rolling_row_tb
// Drives reference and query strings into the rolling-row LCS block with
// random gaps and output stalls, including one long output hold-off, and
// leaves all result checking to lcsrr_checker.
// ----------------------------------------------------------------------------
module lcs_length_rolling_row_tb;
  import lcsrr_pkg::*;
  import lcsrr_tb_pkg::*;

  localparam int CLK_NS       = 20;
  localparam int ITEMS        = 1850;
  localparam int CALM_AT      = ITEMS * 85 / 100;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = 300;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int LIMIT_CYCLES = 800_000;

  logic clk;
  logic rst_n;

  lcsrr_in_if  in_ch ();
  lcsrr_out_if out_ch ();

  int fail_count;
  int pending;
  int results_checked;
  int longest_seen;
  int truncated_seen;

  int         words_sent = 0;
  int         n_refs     = 0;
  int         n_over     = 0;
  int         n_queries  = 0;
  int         gap_rate   = 0;
  bit         calm       = 1'b0;
  logic [7:0] alphabet [6];
  int         alpha_n    = 2;
  logic [7:0] ref_text [$];

  lcs_length_rolling_row u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lcsrr_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .longest_seen    (longest_seen),
    .truncated_seen  (truncated_seen)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_NS / 2) clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_NS);
    $display("lcs_length_rolling_row_tb failed");
    $finish;
  end

  // called at a rising edge, returns at the edge where the word is taken
  task automatic push_word(input word_mode_e m, input logic [7:0] s, input logic l);
    if (!calm && gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= m;
    in_ch.symbol  <= s;
    in_ch.is_last <= l;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    words_sent++;
    if (m == MODE_QUERY && l) n_queries++;
    calm = (words_sent >= CALM_AT);
  endtask

  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    return alphabet[$urandom_range(0, alpha_n - 1)];
  endfunction

  // receiver: random stall bursts, one long hold-off once traffic is going
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && words_sent >= HOLD_AT) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int  ref_n;
    int  q_n;
    int  n_q;
    int  pick;
    bit  partial;
    bit  dup;
    bit  closes;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= MODE_REF;
    in_ch.symbol  <= '0;
    in_ch.is_last <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty reference, symbol extremes, early close, restarts
    push_word(MODE_QUERY, 8'h00, 1'b1);
    push_word(MODE_REF, 8'hFF, 1'b0);
    push_word(MODE_REF, 8'h00, 1'b0);
    push_word(MODE_REF, 8'hFF, 1'b1);
    push_word(MODE_QUERY, 8'hFF, 1'b0);
    push_word(MODE_QUERY, 8'h00, 1'b0);
    push_word(MODE_QUERY, 8'hFF, 1'b1);
    push_word(MODE_QUERY, 8'h00, 1'b1);
    push_word(MODE_QUERY, 8'hAA, 1'b0);
    push_word(MODE_QUERY, 8'h55, 1'b1);
    push_word(MODE_REF, 8'h12, 1'b0);
    push_word(MODE_REF, 8'h34, 1'b0);
    push_word(MODE_QUERY, 8'h34, 1'b1);
    push_word(MODE_REF, 8'h77, 1'b1);
    push_word(MODE_QUERY, 8'h77, 1'b1);
    push_word(MODE_REF, 8'h01, 1'b1);
    push_word(MODE_REF, 8'h02, 1'b1);
    push_word(MODE_QUERY, 8'h01, 1'b0);
    push_word(MODE_QUERY, 8'h02, 1'b1);

    while (words_sent < ITEMS) begin
      pick     = $urandom_range(0, 19);
      gap_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 12);
      if (pick == 0) begin
        repeat ($urandom_range(1, 6))
          push_word(word_mode_e'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
      end else begin
        alpha_n = $urandom_range(2, 6);
        foreach (alphabet[k]) alphabet[k] = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
          0:       ref_n = $urandom_range(60, 70);
          1:       ref_n = MAX_LEN;
          default: ref_n = $urandom_range(1, 40);
        endcase
        partial = (pick == 1);
        ref_text.delete();
        for (int i = 0; i < ref_n; i++) begin
          ref_text.push_back(pick_symbol());
          push_word(MODE_REF, ref_text[i], !partial && i == ref_n - 1);
        end
        n_refs++;
        if (ref_n > MAX_LEN) n_over++;
        n_q = $urandom_range(1, 4);
        for (int q = 0; q < n_q; q++) begin
          dup    = ($urandom_range(0, 7) == 0);
          q_n    = dup ? ref_n :
                   ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 30);
          closes = !(q == n_q - 1 && $urandom_range(0, 9) == 0);
          for (int i = 0; i < q_n; i++)
            push_word(MODE_QUERY, dup ? ref_text[i] : pick_symbol(), closes && i == q_n - 1);
        end
      end
    end
    in_ch.valid <= 1'b0;

    for (int c = 0; c < DRAIN_LIMIT && pending != 0; c++) @(posedge clk);
    if (pending != 0) begin
      $display("timeout: %0d result words never arrived", pending);
      $display("lcs_length_rolling_row_tb failed");
      $finish;
    end else begin
      repeat (MAX_LEN + 16) @(posedge clk);
      if (pending != 0) $display("timeout: %0d result words never arrived", pending);
      $display("Covered %0d words, %0d random references (%0d over capacity), %0d queries.",
               words_sent, n_refs, n_over, n_queries);
      $display("Checked %0d results, %0d flagged truncated, longest LCS %0d.",
               results_checked, truncated_seen, longest_seen);
      if (fail_count == 0 && pending == 0) $display("lcs_length_rolling_row_tb passed");
      else $display("lcs_length_rolling_row_tb failed");
      $finish;
    end
  end

endmodule
